// ----- src/nou_pkg.sv -----
package nou_pkg;

  // Field widths
  localparam int VAL_W      = 32;
  localparam int LAYER_W    = 2;
  localparam int ROW_W      = 6;
  localparam int COL_W      = 6;
  localparam int MODE_W     = 3;
  localparam int COEF_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Default store geometry
  localparam int MAX_LAYERS_DEF = 4;
  localparam int MAX_ROWS_DEF   = 64;
  localparam int MAX_COLS_DEF   = 64;

  // Update rules
  localparam logic [MODE_W-1:0] MODE_SGD      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DECAY    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MOMENTUM = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ADAGRAD  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RMSPROP  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_ADAM     = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_A    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BETA_ONE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BETA_TWO   = 3'd4;

  localparam logic [COEF_W-1:0] POWER_ONE = 16'hFFFF;
  localparam logic [16:0]       ONE_Q16   = 17'h10000;

  // Decay denominator saturates when the product is above this
  localparam logic [63:0] DEN_LIMIT = 64'hFFFF_FFFF_FEFF_FFFF;
  localparam logic [63:0] DEN_BIAS  = 64'h0000_0000_0100_0000;

  localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
  localparam logic signed [65:0] S32_MIN = -66'sd2147483648;

  // Serial unit iteration counts, minus one
  localparam logic [5:0] MUL_STEPS  = 6'd7;
  localparam logic [5:0] DIV_STEPS  = 6'd63;
  localparam logic [5:0] SQRT_STEPS = 6'd23;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_LOAD, ST_STEP,
    ST_DEC_MUL, ST_DEC_DIV, ST_RATE_MUL, ST_MOM_MUL,
    ST_P1_MUL, ST_P2_MUL, ST_M1_MUL, ST_M2_MUL,
    ST_SQ_MUL, ST_V1_MUL, ST_V2_MUL,
    ST_MHAT_DIV, ST_VHAT_DIV, ST_SQRT, ST_AX_MUL, ST_AX_DIV,
    ST_WRITE, ST_OUT
  } state_t;

  typedef enum logic [1:0] {OP_MUL, OP_DIV, OP_SQRT} eng_op_t;

  function automatic logic [31:0] mag32(logic [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

  function automatic logic signed [65:0] apply_sign(logic [63:0] m, logic neg);
    logic signed [65:0] s;
    s = signed'({2'b00, m});
    return neg ? -s : s;
  endfunction

  function automatic logic signed [31:0] sat_s32(logic signed [65:0] x);
    logic signed [31:0] r;
    if (x > S32_MAX) r = 32'sh7FFF_FFFF;
    else if (x < S32_MIN) r = 32'sh8000_0000;
    else r = x[31:0];
    return r;
  endfunction

  function automatic logic [31:0] sat_u32(logic [63:0] x);
    return (x[63:32] != 32'd0) ? 32'hFFFF_FFFF : x[31:0];
  endfunction

endpackage

// ----- src/nou_in_if.sv -----
interface nou_in_if;
  logic                               valid;
  logic                               ready;
  logic                               action;
  logic signed [nou_pkg::VAL_W-1:0]   param_value;
  logic signed [nou_pkg::VAL_W-1:0]   gradient;
  logic        [nou_pkg::LAYER_W-1:0] layer_index;
  logic        [nou_pkg::ROW_W-1:0]   row_index;
  logic        [nou_pkg::COL_W-1:0]   col_index;

  modport source (output valid, action, param_value, gradient, layer_index, row_index,
                  col_index, input ready);
  modport sink (input valid, action, param_value, gradient, layer_index, row_index,
                col_index, output ready);
endinterface

// ----- src/nou_out_if.sv -----
interface nou_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [nou_pkg::VAL_W-1:0] new_value;

  modport source (output valid, new_value, input ready);
  modport sink (input valid, new_value, output ready);
endinterface

// ----- src/neural_optimizer_update.sv -----
// Optimizer update unit: one parameter element (weight or bias) with its gradient
// goes in, the updated element comes out, under SGD, decaying SGD, momentum,
// AdaGrad, RMSProp or Adam as set in the mode register. Values are Q16.16, rates
// Q8.24, coefficients Q0.16 (the decay coefficient Q8.24); other mode values pass
// the element through unchanged. One element is worked on at a time; all
// multiplies, divides and square roots run on one shared serial unit: a 4-bit-digit
// multiplier, a radix-2 divider and a 2-bit-digit square root. The divider
// dominates (three quotients per Adam item). A finished result waits in an output
// register while the next element is taken. After reset the moment stores are
// zeroed, one entry a cycle, over all MAX_LAYERS*MAX_ROWS*MAX_COLS entries (16384
// by default); no element is taken during that pass, configuration writes are.
module neural_optimizer_update #(
  parameter int MAX_LAYERS = nou_pkg::MAX_LAYERS_DEF,
  parameter int MAX_ROWS   = nou_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS   = nou_pkg::MAX_COLS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  nou_in_if.sink                           item,
  nou_out_if.source                        result,
  input  logic                             cfg_write,
  input  logic [nou_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nou_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int WDEPTH = MAX_LAYERS * MAX_ROWS * MAX_COLS;
  localparam int BDEPTH = MAX_LAYERS * MAX_COLS;
  localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int BAW    = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;

  nou_pkg::state_t state, state_next;

  // Configuration
  logic [2:0]  mode_r;
  logic [31:0] learn_rate;
  logic [31:0] coeff_a;
  logic [15:0] beta_one;
  logic [15:0] beta_two;

  // Step state
  logic [31:0] step_count;
  logic [31:0] decayed_rate;
  logic [15:0] beta_one_power;
  logic [15:0] beta_two_power;

  // Item and working registers
  logic               is_bias;
  logic               valid_r;
  logic signed [31:0] p_r;
  logic signed [31:0] g_r;
  logic [WAW-1:0]     w_addr;
  logic [BAW-1:0]     b_addr;
  logic signed [31:0] m_r;
  logic [31:0]        v_r;
  logic [31:0]        sq_r;
  logic signed [65:0] t_r;
  logic [63:0]        den_r;
  logic signed [31:0] ax_r;
  logic [31:0]        as_r;
  logic signed [65:0] result_r;

  // Moment stores
  logic [31:0] weight_first_mem [WDEPTH];
  logic [31:0] weight_second_mem [WDEPTH];
  logic [31:0] bias_first_mem [BDEPTH];
  logic [31:0] bias_second_mem [BDEPTH];
  logic [31:0] wf_rd, ws_rd, bf_rd, bs_rd;
  logic [WAW-1:0] clr_cnt;

  // Output register
  logic               out_valid;
  logic signed [31:0] out_value;

  // Serial arithmetic unit
  logic                 eng_busy;
  logic                 eng_done;
  nou_pkg::eng_op_t     eng_op;
  logic [5:0]           eng_cnt;
  logic [63:0]          eng_x;
  logic [63:0]          eng_y;
  logic [63:0]          eng_acc;
  logic [65:0]          eng_rem;

  // Control outputs
  logic             in_ready;
  logic             accept;
  logic             op_state;
  logic             eng_start;
  nou_pkg::eng_op_t eng_sel;
  logic [63:0]      opa, opb;
  logic             out_free, load_out;
  logic             wr_w, wr_b;
  logic             moment_mode;

  // Input decode
  logic [31:0] w_idx, b_idx;
  logic        in_range;

  // Datapath helpers
  logic [31:0]        gm, mm, axm;
  logic [15:0]        coef2;
  logic signed [65:0] p_ext, rs, mom_new, m2_sum;
  logic [31:0]        sq_val;
  logic [63:0]        v2_sum;
  logic [32:0]        ada_sum;

  assign item.ready       = in_ready;
  assign accept           = item.valid && in_ready;
  assign result.valid     = out_valid;
  assign result.new_value = out_value;

  // Decode element position
  always_comb begin
    w_idx = (32'(item.layer_index) * 32'(MAX_ROWS) + 32'(item.row_index)) * 32'(MAX_COLS)
            + 32'(item.col_index);
    b_idx = 32'(item.layer_index) * 32'(MAX_COLS) + 32'(item.col_index);
    in_range = (32'(item.layer_index) < 32'(MAX_LAYERS))
            && (32'(item.col_index) < 32'(MAX_COLS))
            && (item.action || (32'(item.row_index) < 32'(MAX_ROWS)));
  end

  // Arithmetic helpers
  always_comb begin
    gm      = nou_pkg::mag32(g_r);
    mm      = nou_pkg::mag32(m_r);
    axm     = nou_pkg::mag32(ax_r);
    coef2   = (mode_r == nou_pkg::MODE_ADAM) ? beta_two : coeff_a[15:0];
    p_ext   = 66'(p_r);
    rs      = nou_pkg::apply_sign(eng_acc, g_r[31]) >>> 24;
    mom_new = 66'(nou_pkg::sat_s32(t_r - rs));
    m2_sum  = (t_r + nou_pkg::apply_sign(eng_acc, g_r[31])) >>> 16;
    sq_val  = nou_pkg::sat_u32(eng_acc >> 16);
    v2_sum  = t_r[63:0] + eng_acc;
    ada_sum = {1'b0, v_r} + {1'b0, sq_val};
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      nou_pkg::ST_CLEAR:
        if (clr_cnt == WAW'(WDEPTH - 1)) state_next = nou_pkg::ST_IDLE;
      nou_pkg::ST_IDLE:
        if (accept) state_next = nou_pkg::ST_READ;
      nou_pkg::ST_READ: state_next = nou_pkg::ST_LOAD;
      nou_pkg::ST_LOAD: begin
        case (mode_r)
          nou_pkg::MODE_SGD: state_next = nou_pkg::ST_RATE_MUL;
          nou_pkg::MODE_DECAY:
            state_next = is_bias ? nou_pkg::ST_STEP : nou_pkg::ST_RATE_MUL;
          nou_pkg::MODE_MOMENTUM: state_next = nou_pkg::ST_MOM_MUL;
          nou_pkg::MODE_ADAGRAD: state_next = nou_pkg::ST_SQ_MUL;
          nou_pkg::MODE_RMSPROP: state_next = nou_pkg::ST_SQ_MUL;
          nou_pkg::MODE_ADAM:
            state_next = is_bias ? nou_pkg::ST_STEP : nou_pkg::ST_M1_MUL;
          default: state_next = nou_pkg::ST_WRITE;
        endcase
      end
      nou_pkg::ST_STEP:
        state_next = (mode_r == nou_pkg::MODE_DECAY) ? nou_pkg::ST_DEC_MUL
                                                     : nou_pkg::ST_P1_MUL;
      nou_pkg::ST_DEC_MUL: if (eng_done) state_next = nou_pkg::ST_DEC_DIV;
      nou_pkg::ST_DEC_DIV: if (eng_done) state_next = nou_pkg::ST_RATE_MUL;
      nou_pkg::ST_RATE_MUL: if (eng_done) state_next = nou_pkg::ST_WRITE;
      nou_pkg::ST_MOM_MUL: if (eng_done) state_next = nou_pkg::ST_RATE_MUL;
      nou_pkg::ST_P1_MUL: if (eng_done) state_next = nou_pkg::ST_P2_MUL;
      nou_pkg::ST_P2_MUL: if (eng_done) state_next = nou_pkg::ST_M1_MUL;
      nou_pkg::ST_M1_MUL: if (eng_done) state_next = nou_pkg::ST_M2_MUL;
      nou_pkg::ST_M2_MUL: if (eng_done) state_next = nou_pkg::ST_SQ_MUL;
      nou_pkg::ST_SQ_MUL:
        if (eng_done)
          state_next = (mode_r == nou_pkg::MODE_ADAGRAD) ? nou_pkg::ST_SQRT
                                                         : nou_pkg::ST_V1_MUL;
      nou_pkg::ST_V1_MUL: if (eng_done) state_next = nou_pkg::ST_V2_MUL;
      nou_pkg::ST_V2_MUL:
        if (eng_done)
          state_next = (mode_r == nou_pkg::MODE_ADAM) ? nou_pkg::ST_MHAT_DIV
                                                      : nou_pkg::ST_SQRT;
      nou_pkg::ST_MHAT_DIV: if (eng_done) state_next = nou_pkg::ST_VHAT_DIV;
      nou_pkg::ST_VHAT_DIV: if (eng_done) state_next = nou_pkg::ST_SQRT;
      nou_pkg::ST_SQRT: if (eng_done) state_next = nou_pkg::ST_AX_MUL;
      nou_pkg::ST_AX_MUL: if (eng_done) state_next = nou_pkg::ST_AX_DIV;
      nou_pkg::ST_AX_DIV: if (eng_done) state_next = nou_pkg::ST_WRITE;
      nou_pkg::ST_WRITE: state_next = nou_pkg::ST_OUT;
      nou_pkg::ST_OUT: if (out_free) state_next = nou_pkg::ST_IDLE;
      default: state_next = nou_pkg::ST_IDLE;
    endcase
  end

  // Control outputs and operand selection
  always_comb begin
    in_ready    = (state == nou_pkg::ST_IDLE);
    out_free    = !out_valid || result.ready;
    load_out    = (state == nou_pkg::ST_OUT) && out_free;
    moment_mode = mode_r inside {[nou_pkg::MODE_MOMENTUM:nou_pkg::MODE_ADAM]};
    wr_w = (state == nou_pkg::ST_CLEAR)
        || ((state == nou_pkg::ST_WRITE) && valid_r && !is_bias && moment_mode);
    wr_b = ((state == nou_pkg::ST_CLEAR) && (32'(clr_cnt) < 32'(BDEPTH)))
        || ((state == nou_pkg::ST_WRITE) && valid_r && is_bias && moment_mode);
    op_state = state inside {nou_pkg::ST_DEC_MUL, nou_pkg::ST_DEC_DIV,
                             nou_pkg::ST_RATE_MUL, nou_pkg::ST_MOM_MUL,
                             nou_pkg::ST_P1_MUL, nou_pkg::ST_P2_MUL,
                             nou_pkg::ST_M1_MUL, nou_pkg::ST_M2_MUL,
                             nou_pkg::ST_SQ_MUL, nou_pkg::ST_V1_MUL,
                             nou_pkg::ST_V2_MUL, nou_pkg::ST_MHAT_DIV,
                             nou_pkg::ST_VHAT_DIV, nou_pkg::ST_SQRT,
                             nou_pkg::ST_AX_MUL, nou_pkg::ST_AX_DIV};
    eng_start = op_state && !eng_busy && !eng_done;
    eng_sel   = nou_pkg::OP_MUL;
    opa       = '0;
    opb       = '0;
    case (state)
      nou_pkg::ST_DEC_MUL: begin
        opa = {32'd0, coeff_a};
        opb = {32'd0, step_count};
      end
      nou_pkg::ST_DEC_DIV: begin
        eng_sel = nou_pkg::OP_DIV;
        opa     = {8'd0, learn_rate, 24'd0};
        opb     = den_r;
      end
      nou_pkg::ST_RATE_MUL: begin
        opa = {32'd0, (mode_r == nou_pkg::MODE_DECAY) ? decayed_rate : learn_rate};
        opb = {32'd0, gm};
      end
      nou_pkg::ST_MOM_MUL: begin
        opa = {48'd0, coeff_a[15:0]};
        opb = {32'd0, mm};
      end
      nou_pkg::ST_P1_MUL: begin
        opa = {48'd0, beta_one_power};
        opb = {48'd0, beta_one};
      end
      nou_pkg::ST_P2_MUL: begin
        opa = {48'd0, beta_two_power};
        opb = {48'd0, beta_two};
      end
      nou_pkg::ST_M1_MUL: begin
        opa = {48'd0, beta_one};
        opb = {32'd0, mm};
      end
      nou_pkg::ST_M2_MUL: begin
        opa = {47'd0, nou_pkg::ONE_Q16 - {1'b0, beta_one}};
        opb = {32'd0, gm};
      end
      nou_pkg::ST_SQ_MUL: begin
        opa = {32'd0, gm};
        opb = {32'd0, gm};
      end
      nou_pkg::ST_V1_MUL: begin
        opa = {48'd0, coef2};
        opb = {32'd0, v_r};
      end
      nou_pkg::ST_V2_MUL: begin
        opa = {47'd0, nou_pkg::ONE_Q16 - {1'b0, coef2}};
        opb = {32'd0, sq_r};
      end
      nou_pkg::ST_MHAT_DIV: begin
        eng_sel = nou_pkg::OP_DIV;
        opa     = {16'd0, mm, 16'd0};
        opb     = {47'd0, nou_pkg::ONE_Q16 - {1'b0, beta_one_power}};
      end
      nou_pkg::ST_VHAT_DIV: begin
        eng_sel = nou_pkg::OP_DIV;
        opa     = {16'd0, v_r, 16'd0};
        opb     = {47'd0, nou_pkg::ONE_Q16 - {1'b0, beta_two_power}};
      end
      nou_pkg::ST_SQRT: begin
        eng_sel = nou_pkg::OP_SQRT;
        opa     = {as_r, 32'd0};
      end
      nou_pkg::ST_AX_MUL: begin
        opa = {32'd0, axm};
        opb = {32'd0, learn_rate};
      end
      nou_pkg::ST_AX_DIV: begin
        eng_sel = nou_pkg::OP_DIV;
        opa     = t_r[63:0];
        opb     = den_r;
      end
      default: begin
        eng_sel = nou_pkg::OP_MUL;
      end
    endcase
  end

  // Control state, configuration and step state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= nou_pkg::ST_CLEAR;
      mode_r         <= '0;
      learn_rate     <= '0;
      coeff_a        <= '0;
      beta_one       <= '0;
      beta_two       <= '0;
      step_count     <= '0;
      decayed_rate   <= '0;
      beta_one_power <= nou_pkg::POWER_ONE;
      beta_two_power <= nou_pkg::POWER_ONE;
      clr_cnt        <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        case (cfg_index)
          nou_pkg::REG_MODE:       mode_r     <= cfg_data[2:0];
          nou_pkg::REG_LEARN_RATE: learn_rate <= cfg_data;
          nou_pkg::REG_COEFF_A:    coeff_a    <= cfg_data;
          nou_pkg::REG_BETA_ONE:   beta_one   <= cfg_data[15:0];
          nou_pkg::REG_BETA_TWO:   beta_two   <= cfg_data[15:0];
          default: ;
        endcase
      end
      // sweep the stores after reset
      if (state == nou_pkg::ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      // advance the step on bias items in decay and Adam modes
      if (state == nou_pkg::ST_STEP) step_count <= step_count + 32'd1;
      if (eng_done && (state == nou_pkg::ST_DEC_DIV)) decayed_rate <= eng_x[31:0];
      if (eng_done && (state == nou_pkg::ST_P1_MUL)) beta_one_power <= eng_acc[31:16];
      if (eng_done && (state == nou_pkg::ST_P2_MUL)) beta_two_power <= eng_acc[31:16];
      // drop a taken beat, hold a new one
      if (load_out) out_valid <= 1'b1;
      else if (result.ready) out_valid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load_out) out_value <= nou_pkg::sat_s32(result_r);
  end

  // Item capture and working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      is_bias <= item.action;
      p_r     <= item.param_value;
      g_r     <= item.gradient;
      valid_r <= in_range;
      w_addr  <= w_idx[WAW-1:0];
      b_addr  <= b_idx[BAW-1:0];
    end
    if (state == nou_pkg::ST_LOAD) begin
      m_r      <= !valid_r ? 32'sd0 : (is_bias ? bf_rd : wf_rd);
      v_r      <= !valid_r ? 32'd0 : (is_bias ? bs_rd : ws_rd);
      ax_r     <= g_r;
      result_r <= p_ext;
    end
    if (eng_done) begin
      case (state)
        nou_pkg::ST_DEC_MUL:
          den_r <= (eng_acc > nou_pkg::DEN_LIMIT) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                  : eng_acc + nou_pkg::DEN_BIAS;
        nou_pkg::ST_RATE_MUL: begin
          if (mode_r == nou_pkg::MODE_MOMENTUM) begin
            m_r      <= mom_new[31:0];
            result_r <= p_ext + mom_new;
          end else begin
            result_r <= p_ext - rs;
          end
        end
        nou_pkg::ST_MOM_MUL: t_r <= nou_pkg::apply_sign(eng_acc, m_r[31]) >>> 16;
        nou_pkg::ST_M1_MUL:  t_r <= nou_pkg::apply_sign(eng_acc, m_r[31]);
        nou_pkg::ST_M2_MUL:  m_r <= nou_pkg::sat_s32(m2_sum);
        nou_pkg::ST_SQ_MUL: begin
          sq_r <= sq_val;
          if (mode_r == nou_pkg::MODE_ADAGRAD) begin
            v_r  <= nou_pkg::sat_u32({31'd0, ada_sum});
            as_r <= nou_pkg::sat_u32({31'd0, ada_sum});
          end
        end
        nou_pkg::ST_V1_MUL: t_r <= signed'({2'b00, eng_acc});
        nou_pkg::ST_V2_MUL: begin
          v_r  <= v2_sum[47:16];
          as_r <= v2_sum[47:16];
        end
        nou_pkg::ST_MHAT_DIV:
          ax_r <= nou_pkg::sat_s32(nou_pkg::apply_sign(eng_x, m_r[31]));
        nou_pkg::ST_VHAT_DIV: as_r <= nou_pkg::sat_u32(eng_x);
        nou_pkg::ST_SQRT: den_r <= ({40'd0, eng_acc[23:0]} + 64'd1) << 8;
        nou_pkg::ST_AX_MUL: t_r <= signed'({2'b00, eng_acc});
        nou_pkg::ST_AX_DIV:
          result_r <= p_ext - nou_pkg::apply_sign(eng_x, ax_r[31]);
        default: ;
      endcase
    end
  end

  // Weight moment stores
  always_ff @(posedge clk) begin
    if (wr_w) begin
      weight_first_mem[(state == nou_pkg::ST_CLEAR) ? clr_cnt : w_addr] <=
        (state == nou_pkg::ST_CLEAR) ? 32'd0 : m_r;
      weight_second_mem[(state == nou_pkg::ST_CLEAR) ? clr_cnt : w_addr] <=
        (state == nou_pkg::ST_CLEAR) ? 32'd0 : v_r;
    end
    wf_rd <= weight_first_mem[w_addr];
    ws_rd <= weight_second_mem[w_addr];
  end

  // Bias moment stores
  always_ff @(posedge clk) begin
    if (wr_b) begin
      bias_first_mem[(state == nou_pkg::ST_CLEAR) ? clr_cnt[BAW-1:0] : b_addr] <=
        (state == nou_pkg::ST_CLEAR) ? 32'd0 : m_r;
      bias_second_mem[(state == nou_pkg::ST_CLEAR) ? clr_cnt[BAW-1:0] : b_addr] <=
        (state == nou_pkg::ST_CLEAR) ? 32'd0 : v_r;
    end
    bf_rd <= bias_first_mem[b_addr];
    bs_rd <= bias_second_mem[b_addr];
  end

  // Serial unit: multiply by 4-bit digits, divide one bit a cycle,
  // square root two bits a cycle
  logic [65:0] div_sh, sqrt_sh, sqrt_trial;
  logic        div_ge, sqrt_ge;

  always_comb begin
    div_sh     = {eng_rem[64:0], eng_x[63]};
    div_ge     = div_sh >= {2'b00, eng_y};
    sqrt_sh    = {eng_rem[63:0], eng_x[63:62]};
    sqrt_trial = {eng_acc, 2'b01};
    sqrt_ge    = sqrt_sh >= sqrt_trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eng_busy <= 1'b0;
      eng_done <= 1'b0;
    end else begin
      eng_done <= 1'b0;
      if (eng_start) begin
        eng_busy <= 1'b1;
        eng_op   <= eng_sel;
        eng_x    <= opa;
        eng_y    <= opb;
        eng_acc  <= '0;
        eng_rem  <= '0;
        case (eng_sel)
          nou_pkg::OP_MUL:  eng_cnt <= nou_pkg::MUL_STEPS;
          nou_pkg::OP_DIV:  eng_cnt <= nou_pkg::DIV_STEPS;
          nou_pkg::OP_SQRT: eng_cnt <= nou_pkg::SQRT_STEPS;
          default:          eng_cnt <= nou_pkg::MUL_STEPS;
        endcase
      end else if (eng_busy) begin
        case (eng_op)
          nou_pkg::OP_MUL: begin
            eng_acc <= eng_acc + eng_x * 64'(eng_y[3:0]);
            eng_x   <= eng_x << 4;
            eng_y   <= eng_y >> 4;
          end
          nou_pkg::OP_DIV: begin
            eng_rem <= div_ge ? (div_sh - {2'b00, eng_y}) : div_sh;
            eng_x   <= {eng_x[62:0], div_ge};
          end
          nou_pkg::OP_SQRT: begin
            eng_rem <= sqrt_ge ? (sqrt_sh - sqrt_trial) : sqrt_sh;
            eng_acc <= {eng_acc[62:0], sqrt_ge};
            eng_x   <= eng_x << 2;
          end
          default: ;
        endcase
        if (eng_cnt == 6'd0) begin
          eng_busy <= 1'b0;
          eng_done <= 1'b1;
        end else begin
          eng_cnt <= eng_cnt - 6'd1;
        end
      end
    end
  end

  // Checks
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    eng_done |-> $past(eng_busy))
    else $error("serial unit finished without running");

  a_accept_to_read: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == nou_pkg::ST_READ)
    else $error("accepted beat did not start a store read");

  a_step_only_in_step: assert property (@(posedge clk) disable iff (rst)
    (state != nou_pkg::ST_STEP) |=> $stable(step_count))
    else $error("step count moved outside a bias step");

  a_div_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (eng_busy && eng_op == nou_pkg::OP_DIV) |-> (eng_rem < {2'b00, eng_y}))
    else $error("divider remainder not below divisor");

endmodule

// ----- verif/tb_neural_optimizer_update.sv -----
`timescale 1ns / 100ps

module tb_neural_optimizer_update;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [nou_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [nou_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  nou_in_if item ();
  nou_out_if result ();

  neural_optimizer_update dut (
    .clk(clk), .rst(rst), .item(item.sink), .result(result.source),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  typedef struct packed {
    logic action;
    logic signed [31:0] param_value;
    logic signed [31:0] gradient;
    logic [1:0] layer;
    logic [5:0] row;
    logic [5:0] col;
  } elem_t;

  // Predictor state
  logic signed [31:0] w_m [0:16383];
  logic [31:0] w_v [0:16383];
  logic signed [31:0] b_m [0:255];
  logic [31:0] b_v [0:255];
  logic [31:0] steps, dec_rate;
  logic [15:0] pow_one, pow_two;
  logic [2:0] cur_mode;
  logic [31:0] cur_rate, cur_coeff;
  logic [15:0] cur_b1, cur_b2;

  logic signed [31:0] pending_values[$];
  int mismatches = 0;
  int beats_out = 0;
  int items_in = 0;
  longint cycles = 0;
  bit long_hold = 1'b0;
  bit timed_out = 1'b0;

  function automatic logic signed [31:0] clamp_s(logic signed [65:0] x);
    if (x > 66'sd2147483647) return 32'sh7FFF_FFFF;
    if (x < -66'sd2147483648) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  function automatic logic [31:0] clamp_u(logic [63:0] x);
    return (x > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : x[31:0];
  endfunction

  function automatic logic [31:0] root64(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r[31:0];
  endfunction

  function automatic logic [63:0] abs64(logic signed [31:0] g);
    logic signed [63:0] w;
    w = g;
    return (w < 0) ? -w : w;
  endfunction

  function automatic logic [31:0] grad_sq(logic signed [31:0] g);
    logic [63:0] a;
    a = abs64(g);
    return clamp_u((a * a) >> 16);
  endfunction

  // floor(lr*g / 2^24) via arithmetic shift
  function automatic logic signed [65:0] scaled_rate(logic [31:0] lr, logic signed [31:0] g);
    logic signed [65:0] p;
    p = $signed({34'd0, lr}) * $signed(66'(g));
    return p >>> 24;
  endfunction

  function automatic logic signed [65:0] adapt_step(logic [31:0] lr, logic signed [31:0] x,
                                                    logic [31:0] sv);
    logic [63:0] den, q;
    den = ({32'd0, root64({16'd0, sv, 16'd0})} + 64'd1) << 8;
    q = (abs64(x) * {32'd0, lr}) / den;
    return (x < 0) ? -$signed({2'b00, q}) : $signed({2'b00, q});
  endfunction

  function automatic logic signed [31:0] predict_update(elem_t e);
    int idx;
    logic signed [31:0] m, mhat;
    logic [31:0] v, vhat;
    logic [15:0] a16;
    logic signed [65:0] res, t;
    logic [63:0] prod, den, u;
    idx = e.action ? (e.layer * 64 + e.col) : ((e.layer * 64 + e.row) * 64 + e.col);
    m = e.action ? b_m[idx] : w_m[idx];
    v = e.action ? b_v[idx] : w_v[idx];
    a16 = cur_coeff[15:0];
    res = e.param_value;
    case (cur_mode)
      nou_pkg::MODE_SGD: res = res - scaled_rate(cur_rate, e.gradient);
      nou_pkg::MODE_DECAY: begin
        if (e.action) begin
          steps = steps + 1;
          prod = {32'd0, cur_coeff} * {32'd0, steps};
          den = (prod > nou_pkg::DEN_LIMIT) ? 64'hFFFF_FFFF_FFFF_FFFF
                                            : prod + nou_pkg::DEN_BIAS;
          dec_rate = 32'(({32'd0, cur_rate} << 24) / den);
        end
        res = res - scaled_rate(dec_rate, e.gradient);
      end
      nou_pkg::MODE_MOMENTUM: begin
        t = $signed({50'd0, a16}) * $signed(66'(m));
        m = clamp_s((t >>> 16) - scaled_rate(cur_rate, e.gradient));
        res = res + m;
      end
      nou_pkg::MODE_ADAGRAD: begin
        v = clamp_u({32'd0, v} + {32'd0, grad_sq(e.gradient)});
        res = res - adapt_step(cur_rate, e.gradient, v);
      end
      nou_pkg::MODE_RMSPROP: begin
        u = {48'd0, a16} * {32'd0, v}
            + (64'd65536 - {48'd0, a16}) * {32'd0, grad_sq(e.gradient)};
        v = 32'(u >> 16);
        res = res - adapt_step(cur_rate, e.gradient, v);
      end
      nou_pkg::MODE_ADAM: begin
        if (e.action) begin
          steps = steps + 1;
          pow_one = 16'(({16'd0, pow_one} * {16'd0, cur_b1}) >> 16);
          pow_two = 16'(({16'd0, pow_two} * {16'd0, cur_b2}) >> 16);
        end
        t = $signed({50'd0, cur_b1}) * $signed(66'(m))
            + $signed(66'd65536 - {50'd0, cur_b1}) * $signed(66'(e.gradient));
        m = clamp_s(t >>> 16);
        u = {48'd0, cur_b2} * {32'd0, v}
            + (64'd65536 - {48'd0, cur_b2}) * {32'd0, grad_sq(e.gradient)};
        v = 32'(u >> 16);
        t = ($signed(66'(m)) * 66'sd65536) / $signed(66'd65536 - {50'd0, pow_one});
        mhat = clamp_s(t);
        vhat = clamp_u(({32'd0, v} << 16) / (64'd65536 - {48'd0, pow_two}));
        res = res - adapt_step(cur_rate, mhat, vhat);
      end
      default: ;
    endcase
    if (cur_mode >= nou_pkg::MODE_MOMENTUM && cur_mode <= nou_pkg::MODE_ADAM) begin
      if (e.action) begin
        b_m[idx] = m;
        b_v[idx] = v;
      end else begin
        w_m[idx] = m;
        w_v[idx] = v;
      end
    end
    return clamp_s(res);
  endfunction

  // Drive one register and mirror it; the caller drops the enable
  task automatic write_reg(logic [nou_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      nou_pkg::REG_MODE: cur_mode = val[2:0];
      nou_pkg::REG_LEARN_RATE: cur_rate = val;
      nou_pkg::REG_COEFF_A: cur_coeff = val;
      nou_pkg::REG_BETA_ONE: cur_b1 = val[15:0];
      nou_pkg::REG_BETA_TWO: cur_b2 = val[15:0];
      default: ;
    endcase
  endtask

  // Drop the input and wait until every expected beat is out
  task automatic drain();
    item.valid <= 1'b0;
    while (pending_values.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic configure(logic [2:0] md, logic [31:0] lr, logic [31:0] ca,
                           logic [15:0] b1, logic [15:0] b2);
    drain();
    write_reg(nou_pkg::REG_MODE, {29'd0, md});
    write_reg(nou_pkg::REG_LEARN_RATE, lr);
    write_reg(nou_pkg::REG_COEFF_A, ca);
    write_reg(nou_pkg::REG_BETA_ONE, {16'd0, b1});
    write_reg(nou_pkg::REG_BETA_TWO, {16'd0, b2});
    cfg_write <= 1'b0;
  endtask

  // Offer one beat after a random gap and hold it until taken
  task automatic send_elem(elem_t e, bit no_gap = 1'b0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 14);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      item.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.valid <= 1'b1;
    item.action <= e.action;
    item.param_value <= e.param_value;
    item.gradient <= e.gradient;
    item.layer_index <= e.layer;
    item.row_index <= e.row;
    item.col_index <= e.col;
    do @(negedge clk); while (!item.ready);
    @(posedge clk);
    pending_values.push_back(predict_update(e));
    items_in++;
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 32'($urandom_range(0, 65536 * 4)) - 32'sd131072;
      default: return $urandom;
    endcase
  endfunction

  function automatic elem_t random_elem(bit narrow);
    elem_t e;
    e.action = ($urandom_range(0, 3) == 0);
    e.param_value = pick_value();
    e.gradient = pick_value();
    e.layer = narrow ? 2'($urandom_range(0, 1)) : 2'($urandom);
    e.row = narrow ? 6'($urandom_range(0, 3)) : 6'($urandom);
    e.col = narrow ? 6'($urandom_range(0, 3)) : 6'($urandom);
    return e;
  endfunction

  task automatic test_directed();
    elem_t e;
    for (int md = 0; md < 8; md++) begin
      configure(3'(md), 32'h0100_0000, (md == 1) ? 32'h0080_0000 : 32'h0000_E000,
                16'hE666, 16'hFFBE);
      for (int k = 0; k < 3; k++) begin
        e.action = k[0];
        e.param_value = (k == 2) ? 32'sh7FFF_FFFF : 32'sh8000_0000 + k;
        e.gradient = (k == 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        e.layer = 2'd3;
        e.row = 6'd63;
        e.col = 6'(k * 31);
        send_elem(e);
      end
    end
  endtask

  task automatic test_random_modes();
    logic [2:0] md;
    for (int ph = 0; ph < 24; ph++) begin
      md = (ph < 18) ? 3'(ph % 6) : 3'($urandom_range(0, 7));
      case (ph % 4)
        0: configure(md, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        1: configure(md, 32'd0, 32'd0, 16'd0, 16'd0);
        default: configure(md, $urandom_range(0, 32'h0400_0000), $urandom,
                           16'($urandom), 16'($urandom));
      endcase
      for (int k = 0; k < 80; k++) send_elem(random_elem(k % 3 != 0));
    end
  endtask

  // Fill the block while the receiver holds off, pause until empty, then send ten more
  task automatic test_backpressure();
    configure(nou_pkg::MODE_ADAM, 32'h0010_0000, 32'd0, 16'hE666, 16'hFFBE);
    long_hold = 1'b1;
    for (int k = 0; k < 6; k++) send_elem(random_elem(1'b1), 1'b1);
    drain();
    for (int k = 0; k < 10; k++) send_elem(random_elem(1'b1));
  endtask

  // Sink: random stalls, plus one long hold-off
  initial begin
    int stall;
    result.ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (long_hold) begin
        result.ready <= 1'b0;
        for (int c = 0; c < 3000; c++) @(posedge clk);
        long_hold = 1'b0;
      end else if (stall != 0) begin
        result.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result.ready <= 1'b1;
      do @(negedge clk); while (!result.valid);
      @(posedge clk);
    end
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin
    if (!rst && result.valid && result.ready) begin
      beats_out++;
      if (pending_values.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat new_value=%0d", result.new_value);
      end else if (result.new_value !== pending_values[0]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("new_value mismatch: expected %0d got %0d", pending_values[0],
                   result.new_value);
        void'(pending_values.pop_front());
      end else begin
        void'(pending_values.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 3000000) begin
      $display("tb_neural_optimizer_update NOT OK");
      $finish;
    end
  end

  initial begin
    item.valid = 1'b0;
    item.action = 1'b0;
    item.param_value = '0;
    item.gradient = '0;
    item.layer_index = '0;
    item.row_index = '0;
    item.col_index = '0;
    for (int i = 0; i < 16384; i++) begin
      w_m[i] = 0;
      w_v[i] = 0;
    end
    for (int i = 0; i < 256; i++) begin
      b_m[i] = 0;
      b_v[i] = 0;
    end
    steps = 0;
    dec_rate = 0;
    pow_one = nou_pkg::POWER_ONE;
    pow_two = nou_pkg::POWER_ONE;
    cur_mode = 0;
    cur_rate = 0;
    cur_coeff = 0;
    cur_b1 = 0;
    cur_b2 = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_modes();
    test_backpressure();
    drain();
    $display("Covered %0d elements over all update rules, %0d results checked.",
             items_in, beats_out);
    if (mismatches == 0) begin
      $display("tb_neural_optimizer_update OK");
    end else begin
      $display("tb_neural_optimizer_update NOT OK");
    end
    $finish;
  end

endmodule
